/* rtl/core/block_cache_directory_lru_macros.svh */
// Assertion macros used by the directory top level.
`ifndef BLOCK_CACHE_DIRECTORY_LRU_MACROS_SVH
`define BLOCK_CACHE_DIRECTORY_LRU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCDL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("directory check failed");

// Next-cycle implication, checked outside reset.
`define BCDL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("directory check failed");

`endif

/* rtl/core/bcdl_pkg.sv */
// Package with the beat types, codes and cell control types of the block cache directory.
`timescale 1ns / 1ps
`default_nettype none

package bcdl_pkg;

    // Default sizes.
    localparam int CACHE_ENTRIES_DEF     = 32;
    localparam int BLOCK_NUMBER_BITS_DEF = 32;

    // Configuration register.
    localparam int           CFG_W         = 6;
    localparam logic [5:0]   THRESHOLD_RST = 6'd32;

    // Request actions.
    localparam logic [1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PIN     = 2'd2;
    localparam logic [1:0] ACT_UNPIN   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_FILL    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    // Input beat.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] block_number;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_index;
        logic        evicted;
        logic [31:0] evicted_block;
        logic [5:0]  cached_count;
    } out_beat_t;

    // What the cells do in the update cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MOVE_HIT,
        CELL_MOVE_VICTIM,
        CELL_MOVE_FILL,
        CELL_MARK_REL,
        CELL_MARK_PIN,
        CELL_MARK_UNPIN
    } cell_mode_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic       look;
        logic       apply;
        cell_mode_t mode;
    } cell_ctrl_t;

    // Suffix flags passed from a cell toward the front.
    typedef struct packed {
        logic hit;
        logic elig;
    } cell_sfx_t;

endpackage

`default_nettype wire

/* rtl/core/bcdl_cell.sv */
// One recency position of the directory: entry storage, tag compare and shift logic.
`timescale 1ns / 1ps
`default_nettype none

module bcdl_cell
    import bcdl_pkg::*;
#(
    parameter int TAG_W  = BLOCK_NUMBER_BITS_DEF,
    parameter int SLOT_W = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [TAG_W-1:0]  req_tag,
    input  wire logic              prev_valid,
    input  wire logic [TAG_W-1:0]  prev_tag,
    input  wire logic [SLOT_W-1:0] prev_slot,
    input  wire logic              prev_acq,
    input  wire logic              prev_pin,
    input  wire cell_sfx_t         sfx_in,
    output logic                   valid,
    output logic [TAG_W-1:0]       tag,
    output logic [SLOT_W-1:0]      slot,
    output logic                   acq,
    output logic                   pin,
    output cell_sfx_t              sfx_out,
    output logic                   hit_oh,
    output logic                   vic_oh
);

    logic              valid_reg, valid_next;
    logic              acq_reg, acq_next;
    logic              pin_reg, pin_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              match_reg;
    logic              hit_sfx_reg;
    logic              vic_sfx_reg;
    logic              match;
    logic              elig;
    logic              shift;

    // Compare and victim eligibility of this position.
    assign match = valid_reg && (tag_reg == req_tag);
    assign elig  = valid_reg && !acq_reg && !pin_reg;

    // Suffix flags ripple toward the front; the last eligible cell is the victim.
    assign sfx_out.hit  = match | sfx_in.hit;
    assign sfx_out.elig = elig | sfx_in.elig;
    assign hit_oh       = match;
    assign vic_oh       = elig & !sfx_in.elig;

    // A cell at or in front of the selected position takes its neighbor's entry.
    always_comb begin
        unique case (ctrl.mode)
            CELL_MOVE_HIT:    shift = hit_sfx_reg;
            CELL_MOVE_VICTIM: shift = vic_sfx_reg;
            CELL_MOVE_FILL:   shift = valid_reg | prev_valid;
            default:          shift = 1'b0;
        endcase
    end

    // Next values of the flag bits.
    always_comb begin
        valid_next = valid_reg;
        acq_next   = acq_reg;
        pin_next   = pin_reg;
        if (ctrl.apply) begin
            if (shift) begin
                valid_next = prev_valid;
                acq_next   = prev_acq;
                pin_next   = prev_pin;
            end else if (match_reg) begin
                case (ctrl.mode)
                    CELL_MARK_REL:   acq_next = 1'b0;
                    CELL_MARK_PIN:   pin_next = 1'b1;
                    CELL_MARK_UNPIN: pin_next = 1'b0;
                    default:         ;
                endcase
            end
        end
    end

    // Flag and lookup registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            acq_reg     <= 1'b0;
            pin_reg     <= 1'b0;
            match_reg   <= 1'b0;
            hit_sfx_reg <= 1'b0;
            vic_sfx_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            acq_reg   <= acq_next;
            pin_reg   <= pin_next;
            if (ctrl.look) begin
                match_reg   <= match;
                hit_sfx_reg <= sfx_out.hit;
                vic_sfx_reg <= sfx_out.elig;
            end
        end
    end

    // Tag and slot payload.
    always_ff @(posedge aclk) begin
        if (ctrl.apply && shift) begin
            tag_reg  <= prev_tag;
            slot_reg <= prev_slot;
        end
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign slot  = slot_reg;
    assign acq   = acq_reg;
    assign pin   = pin_reg;

endmodule

`default_nettype wire

/* rtl/core/block_cache_directory_lru.sv */
// Top level of the block cache directory: request control, cell row and result register.
//
// Usage: a request beat (action, block_number) enters on s_valid/s_ready and one result
// beat (status, slot_index, evicted, evicted_block, cached_count) leaves on
// m_valid/m_ready for every request, in request order.
// The row of cells holds the directory in most-recent-first order; every cell compares
// its tag at once and suffix flags ripple along the row to find the hit and the victim.
// An accepted request is looked up in the compare step (S_LOOK), which registers the
// lookup, and the cell row then shifts in the update step (S_UPD), which registers the
// result; a request is taken only while idle or as the last one completes its update.
// The user writes the eviction threshold via cfg_we/cfg_wdata only while no request is
// in work; the block does not enforce this. Reset (aresetn low, synchronous) empties the
// directory, clears all acquired and pinned marks and sets the threshold to 32.
// When the receiver holds m_ready low, the result stays in the output register; the
// request in work waits in the update step until the register is free, and no further
// request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

`include "block_cache_directory_lru_macros.svh"

module block_cache_directory_lru
    import bcdl_pkg::*;
#(
    parameter int CACHE_ENTRIES     = CACHE_ENTRIES_DEF,
    parameter int BLOCK_NUMBER_BITS = BLOCK_NUMBER_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_beat_t         s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_beat_t             m_payload
);

    localparam int TAG_W  = BLOCK_NUMBER_BITS;
    localparam int SLOT_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [1:0]        act_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic              hit_any_reg;
    logic              vic_any_reg;
    logic [SLOT_W-1:0] hit_slot_reg;
    logic              hit_pin_reg;
    logic [SLOT_W-1:0] vic_slot_reg;
    logic [TAG_W-1:0]  vic_tag_reg;
    logic              m_valid_reg;
    out_beat_t         m_payload_reg;

    logic              out_free;
    logic              s_fire;
    logic              proceed;
    cell_ctrl_t        cell_ctrl;
    cell_mode_t        upd_mode;
    out_beat_t         upd_beat;
    logic [SLOT_W-1:0] front_slot;
    logic              front_pin;
    logic              do_fill;

    logic [CACHE_ENTRIES-1:0] valid_vec;
    logic [CACHE_ENTRIES-1:0] acq_vec;
    logic [CACHE_ENTRIES-1:0] pin_vec;
    logic [CACHE_ENTRIES-1:0] hit_oh_vec;
    logic [CACHE_ENTRIES-1:0] vic_oh_vec;
    logic [TAG_W-1:0]         tag_arr  [CACHE_ENTRIES];
    logic [SLOT_W-1:0]        slot_arr [CACHE_ENTRIES];
    cell_sfx_t                sfx_arr  [CACHE_ENTRIES+1];

    logic [SLOT_W-1:0] hit_slot_g;
    logic              hit_pin_g;
    logic [SLOT_W-1:0] vic_slot_g;
    logic [TAG_W-1:0]  vic_tag_g;

    // Handshake.
    assign out_free = !m_valid_reg || m_ready;
    assign proceed  = (state_reg == S_UPD) && out_free;
    assign s_ready  = (state_reg == S_IDLE) || proceed;
    assign s_fire   = s_valid && s_ready;

    // Decision of the update step from the registered lookup.
    always_comb begin
        upd_mode                = CELL_HOLD;
        front_slot              = hit_slot_reg;
        front_pin               = 1'b0;
        do_fill                 = 1'b0;
        upd_beat.status         = ST_HIT;
        upd_beat.slot_index     = 5'(hit_slot_reg);
        upd_beat.evicted        = 1'b0;
        upd_beat.evicted_block  = '0;
        upd_beat.cached_count   = 6'(used_reg);
        unique case (act_reg)
            ACT_ACQUIRE: begin
                if (hit_any_reg) begin
                    upd_mode  = CELL_MOVE_HIT;
                    front_pin = hit_pin_reg;
                end else if (vic_any_reg &&
                             (CMP_W'(used_reg) >= CMP_W'(thr_reg))) begin
                    upd_mode               = CELL_MOVE_VICTIM;
                    front_slot             = vic_slot_reg;
                    upd_beat.status        = ST_FILL;
                    upd_beat.slot_index    = 5'(vic_slot_reg);
                    upd_beat.evicted       = 1'b1;
                    upd_beat.evicted_block = 32'(vic_tag_reg);
                end else if (used_reg < CNT_W'(CACHE_ENTRIES)) begin
                    upd_mode              = CELL_MOVE_FILL;
                    do_fill               = 1'b1;
                    front_slot            = SLOT_W'(used_reg);
                    upd_beat.status       = ST_FILL;
                    upd_beat.slot_index   = 5'(used_reg);
                    upd_beat.cached_count = 6'(used_reg + CNT_W'(1));
                end else begin
                    upd_beat.status     = ST_NO_SLOT;
                    upd_beat.slot_index = '0;
                end
            end
            ACT_RELEASE, ACT_PIN, ACT_UNPIN: begin
                if (hit_any_reg) begin
                    if (act_reg == ACT_RELEASE) begin
                        upd_mode = CELL_MARK_REL;
                    end else if (act_reg == ACT_PIN) begin
                        upd_mode = CELL_MARK_PIN;
                    end else begin
                        upd_mode = CELL_MARK_UNPIN;
                    end
                end else begin
                    upd_beat.status     = ST_ABSENT;
                    upd_beat.slot_index = '0;
                end
            end
            default: ;
        endcase
    end

    // Broadcast control to the row.
    assign cell_ctrl.look  = (state_reg == S_LOOK);
    assign cell_ctrl.apply = proceed;
    assign cell_ctrl.mode  = upd_mode;

    // Row of cells; the front cell takes the entry built here.
    assign sfx_arr[CACHE_ENTRIES] = '0;

    genvar k;
    generate
        for (k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
            logic              p_valid;
            logic [TAG_W-1:0]  p_tag;
            logic [SLOT_W-1:0] p_slot;
            logic              p_acq;
            logic              p_pin;

            if (k == 0) begin : g_front
                assign p_valid = 1'b1;
                assign p_tag   = req_tag_reg;
                assign p_slot  = front_slot;
                assign p_acq   = 1'b1;
                assign p_pin   = front_pin;
            end else begin : g_next
                assign p_valid = valid_vec[k-1];
                assign p_tag   = tag_arr[k-1];
                assign p_slot  = slot_arr[k-1];
                assign p_acq   = acq_vec[k-1];
                assign p_pin   = pin_vec[k-1];
            end

            bcdl_cell #(
                .TAG_W  (TAG_W),
                .SLOT_W (SLOT_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .req_tag    (req_tag_reg),
                .prev_valid (p_valid),
                .prev_tag   (p_tag),
                .prev_slot  (p_slot),
                .prev_acq   (p_acq),
                .prev_pin   (p_pin),
                .sfx_in     (sfx_arr[k+1]),
                .valid      (valid_vec[k]),
                .tag        (tag_arr[k]),
                .slot       (slot_arr[k]),
                .acq        (acq_vec[k]),
                .pin        (pin_vec[k]),
                .sfx_out    (sfx_arr[k]),
                .hit_oh     (hit_oh_vec[k]),
                .vic_oh     (vic_oh_vec[k])
            );
        end
    endgenerate

    // Gather the hit and victim entries through their one-hot selects.
    always_comb begin
        hit_slot_g = '0;
        hit_pin_g  = 1'b0;
        vic_slot_g = '0;
        vic_tag_g  = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            hit_slot_g = hit_slot_g | (slot_arr[i] & {SLOT_W{hit_oh_vec[i]}});
            hit_pin_g  = hit_pin_g | (pin_vec[i] & hit_oh_vec[i]);
            vic_slot_g = vic_slot_g | (slot_arr[i] & {SLOT_W{vic_oh_vec[i]}});
            vic_tag_g  = vic_tag_g | (tag_arr[i] & {TAG_W{vic_oh_vec[i]}});
        end
    end

    // Sequencer, lookup registers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            thr_reg     <= THRESHOLD_RST;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (proceed) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                act_reg     <= s_payload.action;
                req_tag_reg <= TAG_W'(s_payload.block_number);
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    hit_any_reg  <= sfx_arr[0].hit;
                    vic_any_reg  <= sfx_arr[0].elig;
                    hit_slot_reg <= hit_slot_g;
                    hit_pin_reg  <= hit_pin_g;
                    vic_slot_reg <= vic_slot_g;
                    vic_tag_reg  <= vic_tag_g;
                    state_reg    <= S_UPD;
                end
                S_UPD: begin
                    if (proceed) begin
                        m_payload_reg <= upd_beat;
                        if (do_fill) begin
                            used_reg <= used_reg + CNT_W'(1);
                        end
                        state_reg <= s_fire ? S_LOOK : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Checks on the directory row.
    `BCDL_ASSERT_NOW(a_used_matches_row, aclk, aresetn, 1'b1, $countones(valid_vec) == used_reg)
    `BCDL_ASSERT_NOW(a_single_hit, aclk, aresetn, state_reg == S_LOOK, $onehot0(hit_oh_vec))
    `BCDL_ASSERT_NEXT(a_fill_counts, aclk, aresetn, proceed && do_fill, used_reg == $past(used_reg) + 1)
    `BCDL_ASSERT_NOW(a_victim_single, aclk, aresetn, state_reg == S_LOOK, $onehot0(vic_oh_vec))

endmodule

`default_nettype wire
